>>> hw/rtl/multicast_neighbor_table_dr_election_defines.svh
// ----------------------------------------------------------------------------
// neighbor table assertion macros
// shared assertion helpers for the neighbor table block
// ----------------------------------------------------------------------------
`ifndef MULTICAST_NEIGHBOR_TABLE_DR_ELECTION_DEFINES_SVH
`define MULTICAST_NEIGHBOR_TABLE_DR_ELECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define MNT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MNT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define MNT_ASSERT(label, clk, rst_n, prop)
`define MNT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> hw/rtl/mntdr_pkg.sv
// ----------------------------------------------------------------------------
// mntdr_pkg
// types and constants for the neighbor table and dr election
// ----------------------------------------------------------------------------
package mntdr_pkg;
    localparam int MaxNeighbors = 16;
    localparam int IdxW = $clog2(MaxNeighbors);
    localparam int CntW = $clog2(MaxNeighbors + 1);

    localparam logic [1:0] CMD_HELLO = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
    localparam logic [1:0] REG_LOCAL_PRI  = 2'd1;
    localparam logic [1:0] REG_DEF_HOLD   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] nbr_address;
        logic [31:0] generation_id;
        logic        has_holdtime;
        logic [15:0] hold_seconds;
        logic        has_dr_priority;
        logic [31:0] nbr_dr_priority;
        logic        has_lan_delay;
        logic [15:0] lan_delay_word;
        logic [15:0] override_interval;
        logic        has_second_addr;
        logic [31:0] second_address;
    } in_item_t;

    typedef struct packed {
        logic [31:0] dr_address;
        logic        dr_is_local;
        logic        lost_dr_role;
        logic        send_hello;
        logic        table_full;
        logic        expired_any;
        logic [4:0]  neighbor_count;
    } out_item_t;

    // one stored neighbor
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] generation;
        logic        has_pri;
        logic [31:0] prio;
        logic [15:0] hold;
        logic        has_lan;
        logic [15:0] lan;
        logic [15:0] ovr;
        logic [31:0] sec;
    } entry_t;

    // operation applied to every entry in the update rotation
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_HELLO = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       hit_now;
        logic       ins_now;
    } cell_ctl_t;
endpackage

>>> hw/rtl/mntdr_cell.sv
// ----------------------------------------------------------------------------
// mntdr_cell
// one slot of the rotating neighbor ring; applies the current operation, when
// proc is set, to the entry passing through and hands it to the next cell
// ----------------------------------------------------------------------------
module mntdr_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic                proc,
    input  mntdr_pkg::cell_ctl_t ctl,
    input  mntdr_pkg::in_item_t item,
    input  logic [15:0]         hold,
    input  mntdr_pkg::entry_t   ent_in,
    output mntdr_pkg::entry_t   ent_out
);
    import mntdr_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   valid_reg;
    logic   valid_next;
    logic [15:0] dec;

    assign ent_out = '{valid: valid_reg, address: ent_reg.address,
                       generation: ent_reg.generation, has_pri: ent_reg.has_pri,
                       prio: ent_reg.prio, hold: ent_reg.hold,
                       has_lan: ent_reg.has_lan, lan: ent_reg.lan,
                       ovr: ent_reg.ovr, sec: ent_reg.sec};

    always_comb
    begin
        ent_next   = ent_in;
        valid_next = ent_in.valid;
        dec = (ent_in.hold != 16'd0) ? ent_in.hold - 16'd1 : 16'd0;
        if (proc)
        begin
            unique case (ctl.op)
                OP_HELLO:
                begin
                    if (ctl.hit_now)
                    begin
                        ent_next.generation = item.generation_id;
                        ent_next.has_pri = item.has_dr_priority;
                        if (item.has_dr_priority)
                            ent_next.prio = item.nbr_dr_priority;
                        ent_next.has_lan = item.has_lan_delay;
                        if (item.has_lan_delay)
                        begin
                            ent_next.lan = item.lan_delay_word;
                            ent_next.ovr = item.override_interval;
                        end
                        ent_next.sec = item.has_second_addr ? item.second_address : 32'd0;
                        ent_next.hold = hold;
                        if (hold == 16'd0)
                            valid_next = 1'b0;
                    end
                    else if (ctl.ins_now)
                    begin
                        valid_next = 1'b1;
                        ent_next.address = item.nbr_address;
                        ent_next.generation = item.generation_id;
                        ent_next.has_pri = item.has_dr_priority;
                        ent_next.prio = item.has_dr_priority ? item.nbr_dr_priority : 32'd0;
                        ent_next.has_lan = item.has_lan_delay;
                        ent_next.lan = item.has_lan_delay ? item.lan_delay_word : 16'd0;
                        ent_next.ovr = item.has_lan_delay ? item.override_interval : 16'd0;
                        ent_next.sec = item.has_second_addr ? item.second_address : 32'd0;
                        ent_next.hold = hold;
                    end
                end
                OP_TICK:
                begin
                    if (ent_in.valid)
                    begin
                        ent_next.hold = dec;
                        if (dec == 16'd0)
                            valid_next = 1'b0;
                    end
                end
                OP_STOP: valid_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (shift)
            valid_reg <= valid_next;
    end
endmodule

>>> hw/rtl/multicast_neighbor_table_dr_election.sv
// ----------------------------------------------------------------------------
// multicast_neighbor_table_dr_election
// neighbor table with designated router election
// ----------------------------------------------------------------------------
// The table is a ring of sixteen cells that rotates one slot per cycle while
// an item is being worked on. Every item takes two full rotations of the ring
// (lookup, update) and two more (priority scan, election) when the step
// changes the table or a priority. Items are taken one at a time; a finished
// result sits in an output register and the next item may be accepted while
// it waits.
module multicast_neighbor_table_dr_election (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mntdr_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mntdr_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import mntdr_pkg::*;
    `include "multicast_neighbor_table_dr_election_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_PRI  = 3'd3;
    localparam logic [2:0] S_ELEC = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [31:0] laddr_reg, lpri_reg;
    logic [15:0] dhold_reg;
    logic [2:0]  state_reg, state_next;
    logic [IdxW-1:0] pos_reg;
    in_item_t    item_reg;
    logic [15:0] hold_reg;
    logic        hit_reg, slot_reg;
    logic [IdxW-1:0] hit_pos_reg, slot_pos_reg;
    logic        changed_reg, hello_reg, full_reg, expired_reg, bypri_reg;
    logic [CntW-1:0] count_reg;
    logic [31:0] dr_addr_reg, dr_pri_reg;
    logic        dr_mine_reg, was_local_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    entry_t      ring [MaxNeighbors];
    entry_t      head;
    logic        shift, proc;
    cell_ctl_t   ctl;
    logic        last;
    logic        better;

    assign head  = ring[0];
    assign last  = (pos_reg == IdxW'(MaxNeighbors - 1));
    assign shift = (state_reg == S_LOOK) || (state_reg == S_UPD) ||
                   (state_reg == S_PRI) || (state_reg == S_ELEC);
    assign proc  = (state_reg == S_UPD);

    always_comb
    begin
        ctl.op = OP_NONE;
        if (item_reg.cmd == CMD_HELLO)
            ctl.op = OP_HELLO;
        else if (item_reg.cmd == CMD_TICK)
            ctl.op = OP_TICK;
        else if (item_reg.cmd == CMD_STOP)
            ctl.op = OP_STOP;
        ctl.hit_now = hit_reg && (hit_pos_reg == pos_reg);
        ctl.ins_now = !hit_reg && slot_reg && (slot_pos_reg == pos_reg) &&
                      (hold_reg != 16'd0);
    end

    // ring: cell i feeds cell i-1, cell 0 wraps to the last
    for (genvar g = 0; g < MaxNeighbors; g++)
    begin : g_cell
        mntdr_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .shift  (shift),
            .proc   (proc && (g == MaxNeighbors - 1)),
            .ctl    (ctl),
            .item   (item_reg),
            .hold   (hold_reg),
            .ent_in ((g == MaxNeighbors - 1) ? ring[0] : ring[(g + 1) % MaxNeighbors]),
            .ent_out(ring[g])
        );
    end

    always_comb
    begin
        if (bypri_reg)
            better = head.prio > dr_pri_reg ||
                     (head.prio == dr_pri_reg && head.address > dr_addr_reg);
        else
            better = head.address > dr_addr_reg;
    end

    // change caused by the entry at the head during the update pass
    function automatic logic upd_change();
        logic r;
        r = 1'b0;
        unique case (ctl.op)
            OP_HELLO:
            begin
                if (ctl.hit_now)
                    r = (head.has_pri != item_reg.has_dr_priority) ||
                        (item_reg.has_dr_priority && head.prio != item_reg.nbr_dr_priority) ||
                        (hold_reg == 16'd0);
                else if (ctl.ins_now)
                    r = 1'b1;
            end
            OP_TICK: r = head.valid && (head.hold <= 16'd1);
            OP_STOP: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic changed_next_any();
        return changed_reg || upd_change();
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid && !in_stall) state_next = S_LOOK;
            S_LOOK: if (last) state_next = S_UPD;
            S_UPD:  if (last) state_next = changed_next_any() ? S_PRI : S_DONE;
            S_PRI:  if (last) state_next = S_ELEC;
            S_ELEC: if (last) state_next = S_DONE;
            S_DONE: if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            laddr_reg <= 32'd0;
            lpri_reg  <= 32'd1;
            dhold_reg <= 16'd105;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOCAL_ADDR: laddr_reg <= cfg_data;
                REG_LOCAL_PRI:  lpri_reg  <= cfg_data;
                REG_DEF_HOLD:   dhold_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
            hold_reg <= in_data.has_holdtime ? in_data.hold_seconds : dhold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            hit_reg       <= 1'b0;
            slot_reg      <= 1'b0;
            hit_pos_reg   <= '0;
            slot_pos_reg  <= '0;
            changed_reg   <= 1'b0;
            hello_reg     <= 1'b0;
            full_reg      <= 1'b0;
            expired_reg   <= 1'b0;
            bypri_reg     <= 1'b1;
            count_reg     <= '0;
            dr_addr_reg   <= 32'd0;
            dr_pri_reg    <= 32'd1;
            dr_mine_reg   <= 1'b1;
            was_local_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (shift)
                pos_reg <= last ? '0 : pos_reg + IdxW'(1);
            unique case (state_reg)
                S_IDLE:
                begin
                    pos_reg     <= '0;
                    hit_reg     <= 1'b0;
                    slot_reg    <= 1'b0;
                    changed_reg <= 1'b0;
                    hello_reg   <= 1'b0;
                    full_reg    <= 1'b0;
                    expired_reg <= 1'b0;
                    bypri_reg   <= 1'b1;
                end
                S_LOOK:
                begin
                    if (head.valid)
                    begin
                        if (!hit_reg && head.address == item_reg.nbr_address)
                        begin
                            hit_reg     <= 1'b1;
                            hit_pos_reg <= pos_reg;
                        end
                    end
                    else if (!slot_reg)
                    begin
                        slot_reg     <= 1'b1;
                        slot_pos_reg <= pos_reg;
                    end
                    if (last && item_reg.cmd == CMD_HELLO && !hit_reg && !slot_reg &&
                        !(head.valid && head.address == item_reg.nbr_address) && head.valid)
                        full_reg <= 1'b1;
                end
                S_UPD:
                begin
                    if (upd_change())
                        changed_reg <= 1'b1;
                    unique case (ctl.op)
                        OP_HELLO:
                        begin
                            if (ctl.hit_now)
                            begin
                                if (head.generation != item_reg.generation_id)
                                    hello_reg <= 1'b1;
                                if (hold_reg == 16'd0)
                                begin
                                    expired_reg <= 1'b1;
                                    count_reg   <= count_reg - CntW'(1);
                                end
                            end
                            else if (ctl.ins_now)
                            begin
                                hello_reg <= 1'b1;
                                count_reg <= count_reg + CntW'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            if (head.valid && head.hold <= 16'd1)
                            begin
                                expired_reg <= 1'b1;
                                count_reg   <= count_reg - CntW'(1);
                            end
                        end
                        OP_STOP:
                        begin
                            if (head.valid)
                                expired_reg <= 1'b1;
                            count_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                S_PRI:
                begin
                    if (head.valid && !head.has_pri)
                        bypri_reg <= 1'b0;
                    if (last)
                    begin
                        was_local_reg <= dr_mine_reg;
                        dr_addr_reg   <= laddr_reg;
                        dr_pri_reg    <= lpri_reg;
                        dr_mine_reg   <= 1'b1;
                    end
                end
                S_ELEC:
                begin
                    if (head.valid && better)
                    begin
                        dr_addr_reg <= head.address;
                        dr_pri_reg  <= head.prio;
                        dr_mine_reg <= 1'b0;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg.dr_address     <= dr_addr_reg;
                        out_reg.dr_is_local    <= dr_mine_reg;
                        out_reg.lost_dr_role   <= changed_reg && was_local_reg && !dr_mine_reg;
                        out_reg.send_hello     <= hello_reg;
                        out_reg.table_full     <= full_reg;
                        out_reg.expired_any    <= expired_reg;
                        out_reg.neighbor_count <= 5'(count_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    `MNT_ASSERT(a_count_range, clk, rst_n, count_reg <= CntW'(MaxNeighbors))
    `MNT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n,
        (state_reg == S_IDLE) && in_valid && !in_stall, state_reg == S_LOOK)
    `MNT_ASSERT(a_ring_moves_busy, clk, rst_n, !shift || (state_reg != S_IDLE))
    `MNT_ASSERT_NEXT(a_done_emits, clk, rst_n,
        (state_reg == S_DONE) && !out_valid_reg, out_valid_reg)
endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the neighbor table and dr election block: a
// directed table of hellos, ticks and stops, then random traffic on a small
// address pool, checked transfer by transfer against a local table model
// ----------------------------------------------------------------------------
module tb;
    import mntdr_pkg::*;

    localparam int InW = $bits(in_item_t);
    localparam logic [1:0] CmdUnused = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] generation;
        logic        has_pri;
        logic [31:0] prio;
        logic [15:0] hold;
    } nbr_t;

    typedef struct {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    nbr_t        nbrs [MaxNeighbors];
    logic [31:0] my_addr;
    logic [31:0] my_pri;
    logic [15:0] my_hold;
    logic [31:0] dr_addr;
    logic [31:0] dr_pri;
    logic        dr_mine;
    int          nbr_count;

    out_item_t   pending_results [$];
    out_item_t   typed_results [$];
    logic        typed_flags [$];
    row_t        rows [$];
    int          errors;
    int          accepted;
    int          received;
    int          idle_cycles;
    logic [31:0] addr_pool [8];

    multicast_neighbor_table_dr_election i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic run_election();
        logic was_local;
        logic by_pri;
        logic better;
        was_local = dr_mine;
        by_pri = 1'b1;
        for (int i = 0; i < MaxNeighbors; i++)
            if (nbrs[i].valid && !nbrs[i].has_pri)
                by_pri = 1'b0;
        dr_addr = my_addr;
        dr_pri = my_pri;
        dr_mine = 1'b1;
        for (int i = 0; i < MaxNeighbors; i++)
        begin
            if (!nbrs[i].valid)
                continue;
            if (by_pri)
                better = nbrs[i].prio > dr_pri ||
                         (nbrs[i].prio == dr_pri && nbrs[i].address > dr_addr);
            else
                better = nbrs[i].address > dr_addr;
            if (better)
            begin
                dr_addr = nbrs[i].address;
                dr_pri = nbrs[i].prio;
                dr_mine = 1'b0;
            end
        end
        return was_local && !dr_mine;
    endfunction

    function automatic out_item_t predict_step(in_item_t it);
        out_item_t   r;
        logic        changed;
        logic [15:0] hold;
        int          hit;
        int          slot;
        r = '0;
        changed = 1'b0;
        if (it.cmd == CMD_HELLO)
        begin
            hold = it.has_holdtime ? it.hold_seconds : my_hold;
            hit = -1;
            slot = -1;
            for (int i = 0; i < MaxNeighbors; i++)
                if (nbrs[i].valid)
                begin
                    if (hit < 0 && nbrs[i].address == it.nbr_address)
                        hit = i;
                end
                else if (slot < 0)
                    slot = i;
            if (hit >= 0)
            begin
                if (nbrs[hit].generation != it.generation_id)
                begin
                    nbrs[hit].generation = it.generation_id;
                    r.send_hello = 1'b1;
                end
                if (nbrs[hit].has_pri != it.has_dr_priority ||
                    (it.has_dr_priority && nbrs[hit].prio != it.nbr_dr_priority))
                    changed = 1'b1;
                nbrs[hit].has_pri = it.has_dr_priority;
                if (it.has_dr_priority)
                    nbrs[hit].prio = it.nbr_dr_priority;
                nbrs[hit].hold = hold;
                if (hold == 0)
                begin
                    nbrs[hit].valid = 1'b0;
                    nbr_count--;
                    r.expired_any = 1'b1;
                    changed = 1'b1;
                end
            end
            else if (slot < 0)
                r.table_full = 1'b1;
            else if (hold != 0)
            begin
                nbrs[slot].valid = 1'b1;
                nbrs[slot].address = it.nbr_address;
                nbrs[slot].generation = it.generation_id;
                nbrs[slot].has_pri = it.has_dr_priority;
                nbrs[slot].prio = it.has_dr_priority ? it.nbr_dr_priority : 32'd0;
                nbrs[slot].hold = hold;
                nbr_count++;
                r.send_hello = 1'b1;
                changed = 1'b1;
            end
        end
        else if (it.cmd == CMD_TICK)
        begin
            for (int i = 0; i < MaxNeighbors; i++)
            begin
                if (!nbrs[i].valid)
                    continue;
                if (nbrs[i].hold > 0)
                    nbrs[i].hold--;
                if (nbrs[i].hold == 0)
                begin
                    nbrs[i].valid = 1'b0;
                    nbr_count--;
                    r.expired_any = 1'b1;
                    changed = 1'b1;
                end
            end
        end
        else if (it.cmd == CMD_STOP)
        begin
            for (int i = 0; i < MaxNeighbors; i++)
                if (nbrs[i].valid)
                begin
                    r.expired_any = 1'b1;
                    nbrs[i].valid = 1'b0;
                end
            nbr_count = 0;
            changed = 1'b1;
        end
        if (changed)
            r.lost_dr_role = run_election();
        r.dr_address = dr_addr;
        r.dr_is_local = dr_mine;
        r.neighbor_count = nbr_count[4:0];
        return r;
    endfunction

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       p;
        it = in_item_t'(InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        p = $urandom_range(0, 99);
        if (p < 70)
        begin
            it.cmd = CMD_HELLO;
            it.nbr_address = addr_pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 3) != 0)
                it.nbr_address[3:0] = 4'($urandom_range(0, 15));
            it.generation_id = 32'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                it.generation_id = $urandom;
            it.hold_seconds = $urandom_range(0, 9) == 0 ? 16'd0
                                                         : 16'($urandom_range(1, 12));
            if ($urandom_range(0, 19) == 0)
                it.hold_seconds = 16'($urandom);
            it.has_dr_priority = $urandom_range(0, 5) != 0;
            if ($urandom_range(0, 2) != 0)
                it.nbr_dr_priority = 32'($urandom_range(0, 4));
        end
        else if (p < 95)
            it.cmd = CMD_TICK;
        else if (p < 98)
            it.cmd = CMD_STOP;
        else
            it.cmd = CmdUnused;
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        repeat (gap_length())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_step(it));
        accepted++;
    endtask

    task automatic drain_and_write(logic [1:0] idx, logic [31:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LOCAL_ADDR)
            my_addr = val;
        else if (idx == REG_LOCAL_PRI)
            my_pri = val;
        else
            my_hold = val[15:0];
    endtask

    function automatic in_item_t hello(logic [31:0] a, logic [31:0] g, logic hh,
                                       logic [15:0] hs, logic hp, logic [31:0] p);
        in_item_t it;
        it = '0;
        it.cmd = CMD_HELLO;
        it.nbr_address = a;
        it.generation_id = g;
        it.has_holdtime = hh;
        it.hold_seconds = hs;
        it.has_dr_priority = hp;
        it.nbr_dr_priority = p;
        it.has_lan_delay = 1'b1;
        it.lan_delay_word = 16'hFFFF;
        it.override_interval = 16'hFFFF;
        it.has_second_addr = 1'b1;
        it.second_address = 32'hFFFF_FFFF;
        return it;
    endfunction

    function automatic void add_row(in_item_t it, logic typed, out_item_t want);
        row_t r;
        r.item = it;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            received++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (typed_flags.size() != 0 && typed_flags.pop_front())
                    want = typed_results.pop_front();
                if (out_data.dr_address !== want.dr_address ||
                    out_data.dr_is_local !== want.dr_is_local ||
                    out_data.lost_dr_role !== want.lost_dr_role ||
                    out_data.send_hello !== want.send_hello ||
                    out_data.table_full !== want.table_full ||
                    out_data.expired_any !== want.expired_any ||
                    out_data.neighbor_count !== want.neighbor_count)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 8)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 60)
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        out_item_t   w;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LOCAL_ADDR;
        cfg_data = '0;
        errors = 0;
        accepted = 0;
        received = 0;
        idle_cycles = 0;
        my_addr = 32'd0;
        my_pri = 32'd1;
        my_hold = 16'd105;
        dr_addr = 32'd0;
        dr_pri = 32'd1;
        dr_mine = 1'b1;
        nbr_count = 0;
        for (int i = 0; i < MaxNeighbors; i++)
            nbrs[i] = '0;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFF0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: after reset, extremes, full table, zero hold cases
        w = '0;
        w.dr_is_local = 1'b1;
        add_row({CMD_TICK, {(InW - 2){1'b0}}}, 1'b1, w);
        w.send_hello = 1'b1;
        w.neighbor_count = 5'd1;
        w.dr_address = 32'hFFFF_FFFF;
        w.dr_is_local = 1'b0;
        w.lost_dr_role = 1'b1;
        add_row(hello(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF),
                1'b1, w);
        add_row(hello(32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0), 1'b0, w);
        add_row(hello(32'd5, 32'd1, 1'b1, 16'd0, 1'b1, 32'd9), 1'b0, w);
        add_row(hello(32'hFFFF_FFFF, 32'd0, 1'b1, 16'd0, 1'b0, 32'd0), 1'b0, w);
        for (int i = 0; i < 17; i++)
            add_row(hello(32'h100 + i, 32'd0, 1'b1, 16'd2, 1'b1, 32'(i)), 1'b0, w);
        add_row(hello(32'h999, 32'd0, 1'b1, 16'd0, 1'b1, 32'd0), 1'b0, w);
        add_row({CMD_TICK, {(InW - 2){1'b0}}}, 1'b0, w);
        add_row({CmdUnused, {(InW - 2){1'b1}}}, 1'b0, w);
        add_row({CMD_TICK, {(InW - 2){1'b0}}}, 1'b0, w);
        add_row({CMD_STOP, {(InW - 2){1'b0}}}, 1'b0, w);
        foreach (rows[i])
        begin
            typed_flags.push_back(rows[i].typed);
            if (rows[i].typed)
                typed_results.push_back(rows[i].want);
            send_item(rows[i].item);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin
                    drain_and_write(REG_LOCAL_ADDR, 32'hFFFF_FFFF);
                    drain_and_write(REG_LOCAL_PRI, 32'hFFFF_FFFF);
                    drain_and_write(REG_DEF_HOLD, 32'd1);
                end
                1: begin
                    drain_and_write(REG_LOCAL_ADDR, 32'd0);
                    drain_and_write(REG_LOCAL_PRI, 32'd0);
                    drain_and_write(REG_DEF_HOLD, 32'd65535);
                end
                2: begin
                    drain_and_write(REG_LOCAL_ADDR, $urandom);
                    drain_and_write(REG_LOCAL_PRI, 32'd2);
                    drain_and_write(REG_DEF_HOLD, 32'd6);
                end
                3: drain_and_write(REG_LOCAL_PRI, $urandom);
                default: drain_and_write(REG_DEF_HOLD, 32'd105);
            endcase
            for (int n = 0; n < 100; n++)
                send_item(random_item());
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        $display("covered %0d items and %0d results over five register settings",
                 accepted, received);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
